// ===== rtl/overwrite_ring_queue_generation_unit_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef OVERWRITE_RING_QUEUE_GENERATION_UNIT_MACROS_SVH
`define OVERWRITE_RING_QUEUE_GENERATION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ORQG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("orqg same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ORQG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("orqg next-cycle check failed");

`endif

// ===== rtl/orqg_pkg.sv =====
`timescale 1ns / 1ps

package orqg_pkg;

    localparam int CAPACITY    = 32;
    localparam int SAMPLE_BITS = 64;
    localparam int MAX_RESULTS = 32;

    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 64;
    localparam int REQ_W    = 8;
    localparam int GEN_W    = 32;
    localparam int POS_W    = 5;
    localparam int HELD_W   = 6;

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PEEK_MAX = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
    localparam int PCNT_W   = $clog2(PEEK_MAX + 1);
    localparam int CMP_W    = (REQ_W > CNT_W) ? REQ_W : CNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_DISCARD = 2'd2,
        CMD_SIZE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_PEEK_ISSUE,
        ST_PEEK_DRAIN
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        t_cmd op;
        logic load_single;
        logic rd_issue;
        logic rd_move;
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic empty;
        logic rd_vld;
        logic issue_last;
    } t_dp_status;

    // Reduces a sum of two ring offsets, known to stay below twice the capacity.
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
        logic [IDX_W:0] cap;
        cap = (IDX_W + 1)'(CAPACITY);
        return (s >= cap) ? IDX_W'(s - cap) : IDX_W'(s);
    endfunction

endpackage

// ===== rtl/orqg_in_if.sv =====
`timescale 1ns / 1ps

interface orqg_in_if;
    import orqg_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [SAMPLE_W-1:0] sample_data;
    logic [REQ_W-1:0]    discard_request;
    logic [GEN_W-1:0]    seen_generation;

    modport source (
        output valid, command, sample_data, discard_request, seen_generation,
        input  ready
    );
    modport sink (
        input  valid, command, sample_data, discard_request, seen_generation,
        output ready
    );
endinterface

// ===== rtl/orqg_out_if.sv =====
`timescale 1ns / 1ps

interface orqg_out_if;
    import orqg_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] stored_sample;
    logic [POS_W-1:0]    position;
    logic [HELD_W-1:0]   held_count;
    logic [GEN_W-1:0]    generation_now;
    logic                sample_valid;
    logic                discard_done;
    logic                last;

    modport source (
        output valid, stored_sample, position, held_count, generation_now,
               sample_valid, discard_done, last,
        input  ready
    );
    modport sink (
        input  valid, stored_sample, position, held_count, generation_now,
               sample_valid, discard_done, last,
        output ready
    );
endinterface

// ===== rtl/orqg_ram.sv =====
`timescale 1ns / 1ps

module orqg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/orqg_datapath.sv =====
`timescale 1ns / 1ps

module orqg_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  orqg_pkg::t_ctrl_cmd           i_cmd,
    output orqg_pkg::t_dp_status          o_status,
    input  logic [orqg_pkg::SAMPLE_W-1:0] i_sample_data,
    input  logic [orqg_pkg::REQ_W-1:0]    i_discard_request,
    input  logic [orqg_pkg::GEN_W-1:0]    i_seen_generation,
    orqg_out_if.source                    o_out
);
    import orqg_pkg::*;

    // Ring state.
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [GEN_W-1:0]  r_gen, n_gen;

    // Values captured when a command is accepted.
    logic [CNT_W-1:0]  r_pend_held;
    logic [GEN_W-1:0]  r_pend_gen;
    logic              r_pend_done;

    // Peek sequencing and the read stage.
    logic [PCNT_W-1:0] r_pk_n;
    logic [PCNT_W-1:0] r_pk_i;
    logic              r_rd_vld;
    logic [PCNT_W-1:0] r_rd_pos;
    logic              r_rd_last;

    // Output register.
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [POS_W-1:0]    r_out_pos;
    logic [HELD_W-1:0]   r_out_held;
    logic [GEN_W-1:0]    r_out_gen;
    logic                r_out_svalid;
    logic                r_out_done;
    logic                r_out_last;

    logic                   full;
    logic                   gen_match;
    logic [CNT_W-1:0]       drop;
    logic [PCNT_W-1:0]      peek_n;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   disc_ok;

    assign full      = (r_fill == CNT_W'(CAPACITY));
    assign gen_match = (i_seen_generation == r_gen);
    assign drop      = (CMP_W'(i_discard_request) > CMP_W'(r_fill)) ?
                       r_fill : CNT_W'(i_discard_request);
    assign peek_n    = (CMP_W'(r_fill) > CMP_W'(PEEK_MAX)) ?
                       PCNT_W'(PEEK_MAX) : PCNT_W'(r_fill);
    assign disc_ok   = i_cmd.accept && (i_cmd.op == CMD_DISCARD) && gen_match;

    assign wr_en   = i_cmd.accept && (i_cmd.op == CMD_ENQUEUE);
    assign wr_addr = full ? r_head :
                     wrap_idx((IDX_W + 1)'(r_head) + (IDX_W + 1)'(r_fill));
    assign rd_addr = wrap_idx((IDX_W + 1)'(r_head) + (IDX_W + 1)'(r_pk_i));

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        n_gen  = r_gen;
        if (wr_en) begin
            if (full) begin
                n_head = wrap_idx((IDX_W + 1)'(r_head) + (IDX_W + 1)'(1));
            end else begin
                n_fill = r_fill + CNT_W'(1);
            end
            n_gen = r_gen + GEN_W'(1);
        end else if (disc_ok) begin
            n_head = wrap_idx((IDX_W + 1)'(r_head) + (IDX_W + 1)'(drop));
            n_fill = r_fill - drop;
            n_gen  = r_gen + GEN_W'(1);
        end
    end

    orqg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample_data[SAMPLE_BITS-1:0]),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_fill    <= '0;
            r_gen     <= '0;
            r_pk_n    <= '0;
            r_pk_i    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            r_gen  <= n_gen;

            if (i_cmd.accept) begin
                r_pk_n <= peek_n;
                r_pk_i <= '0;
            end else if (i_cmd.rd_issue) begin
                r_pk_i <= r_pk_i + PCNT_W'(1);
            end

            if (i_cmd.rd_issue) begin
                r_rd_vld <= 1'b1;
            end else if (i_cmd.rd_move) begin
                r_rd_vld <= 1'b0;
            end

            if (i_cmd.load_single || i_cmd.rd_move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_held <= r_fill;
            r_pend_gen  <= n_gen;
            r_pend_done <= disc_ok;
        end
        if (i_cmd.rd_issue) begin
            r_rd_pos  <= r_pk_i;
            r_rd_last <= o_status.issue_last;
        end
        if (i_cmd.load_single) begin
            r_out_sample <= '0;
            r_out_pos    <= '0;
            r_out_held   <= HELD_W'(r_pend_held);
            r_out_gen    <= r_pend_gen;
            r_out_svalid <= 1'b0;
            r_out_done   <= r_pend_done;
            r_out_last   <= 1'b1;
        end else if (i_cmd.rd_move) begin
            r_out_sample <= SAMPLE_W'(rd_data);
            r_out_pos    <= POS_W'(r_rd_pos);
            r_out_held   <= HELD_W'(r_pend_held);
            r_out_gen    <= r_pend_gen;
            r_out_svalid <= 1'b1;
            r_out_done   <= 1'b0;
            r_out_last   <= r_rd_last;
        end
    end

    assign o_status.out_free   = !r_out_vld || o_out.ready;
    assign o_status.empty      = (r_fill == '0);
    assign o_status.rd_vld     = r_rd_vld;
    assign o_status.issue_last = (r_pk_i == PCNT_W'(r_pk_n - PCNT_W'(1)));

    assign o_out.valid          = r_out_vld;
    assign o_out.stored_sample  = r_out_sample;
    assign o_out.position       = r_out_pos;
    assign o_out.held_count     = r_out_held;
    assign o_out.generation_now = r_out_gen;
    assign o_out.sample_valid   = r_out_svalid;
    assign o_out.discard_done   = r_out_done;
    assign o_out.last           = r_out_last;
endmodule

// ===== rtl/orqg_controller.sv =====
`timescale 1ns / 1ps

module orqg_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  orqg_pkg::t_cmd       i_in_command,
    output logic                 o_in_ready,
    input  orqg_pkg::t_dp_status i_status,
    output orqg_pkg::t_ctrl_cmd  o_cmd
);
    import orqg_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;
    assign accept     = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_command)
                        CMD_ENQUEUE: n_state = ST_IDLE;
                        CMD_PEEK:    n_state = i_status.empty ? ST_SINGLE : ST_PEEK_ISSUE;
                        default:     n_state = ST_SINGLE;
                    endcase
                end
            end
            ST_SINGLE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PEEK_ISSUE: begin
                if ((!i_status.rd_vld || i_status.out_free) && i_status.issue_last) begin
                    n_state = ST_PEEK_DRAIN;
                end
            end
            ST_PEEK_DRAIN: begin
                if (!i_status.rd_vld || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept      = accept;
        o_cmd.op          = i_in_command;
        o_cmd.load_single = 1'b0;
        o_cmd.rd_issue    = 1'b0;
        o_cmd.rd_move     = i_status.rd_vld && i_status.out_free;
        unique case (r_state)
            ST_IDLE:       ;
            ST_SINGLE:     o_cmd.load_single = i_status.out_free;
            ST_PEEK_ISSUE: o_cmd.rd_issue = !i_status.rd_vld || i_status.out_free;
            ST_PEEK_DRAIN: ;
            default:       ;
        endcase
    end
endmodule

// ===== rtl/overwrite_ring_queue_generation_unit.sv =====
// Overwrite-oldest ring queue of CAPACITY samples with a 32-bit generation
// counter. Enqueues may follow each other in every cycle; when the ring is
// full the oldest sample is replaced. A size query or a discard is accepted,
// then its single result is loaded into the output register, before the next
// transaction is taken. During a peek, while the sink keeps ready high, the
// single read port of the sample store delivers one registered sample per
// cycle into the output register, and the block takes no new transaction
// until the last one has left the read stage. An empty peek, a size query
// and a discard each give one result with last set; an enqueue gives none.
`timescale 1ns / 1ps

module overwrite_ring_queue_generation_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    orqg_in_if.sink    i_in,
    orqg_out_if.source o_out
);
    import orqg_pkg::*;

    // Commands flow from the controller to the datapath; the datapath reports
    // ring emptiness, read-stage occupancy, output-register space and peek progress back.
    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // The controller owns the input handshake; a transaction is taken only
    // in its idle state, so a multi-result command finishes before the next.
    orqg_controller u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (t_cmd'(i_in.command)),
        .o_in_ready   (i_in.ready),
        .i_status     (dp_status),
        .o_cmd        (ctrl_cmd)
    );

    // The datapath holds the ring pointers, the generation counter, the
    // sample store and the output register that drives the result channel.
    orqg_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctrl_cmd),
        .o_status          (dp_status),
        .i_sample_data     (i_in.sample_data),
        .i_discard_request (i_in.discard_request),
        .i_seen_generation (i_in.seen_generation),
        .o_out             (o_out)
    );
endmodule

// ===== rtl/orqg_checker.sv =====
`timescale 1ns / 1ps
`include "overwrite_ring_queue_generation_unit_macros.svh"

module orqg_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic [orqg_pkg::CMD_W-1:0] i_in_command,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_sample_valid,
    input logic                       i_out_discard_done,
    input logic                       i_out_last
);
    import orqg_pkg::*;

    // A stalled result stays offered.
    `ORQG_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // Any command that yields results keeps the input blocked in the cycle after its acceptance.
    `ORQG_ASSERT_NEXT(a_busy_after_cmd, i_in_valid && i_in_ready && i_in_command != CMD_ENQUEUE, !i_in_ready)
    // A result that carries no sample is the only result of its command.
    `ORQG_ASSERT_SAME(a_single_last, i_out_valid && !i_out_sample_valid, i_out_last)
    // A peeked sample never reports an applied discard.
    `ORQG_ASSERT_SAME(a_sample_not_done, i_out_valid && i_out_sample_valid, !i_out_discard_done)
endmodule

bind overwrite_ring_queue_generation_unit orqg_checker u_orqg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_command       (i_in.command),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_sample_valid (o_out.sample_valid),
    .i_out_discard_done (o_out.discard_done),
    .i_out_last         (o_out.last)
);
